>>> design/mips_load_store_align_merge_core_defines.svh
// assertion macros for the load/store align and merge core
// no dependencies; included by files that carry concurrent assertions
`ifndef MIPS_LOAD_STORE_ALIGN_MERGE_CORE_DEFINES_SVH
`define MIPS_LOAD_STORE_ALIGN_MERGE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MLSAM_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("mlsam assertion failed");

// next-cycle implication, disabled while reset is asserted
`define MLSAM_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("mlsam assertion failed");

`endif

>>> design/mlsam_pkg.sv
// shared types and constants for the load/store align and merge core
// no dependencies
package mlsam_pkg;

    localparam int unsigned CMD_W  = 5;
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned SIZE_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_LB    = 5'd0,
        CMD_LBU   = 5'd1,
        CMD_LH    = 5'd2,
        CMD_LHU   = 5'd3,
        CMD_LW    = 5'd4,
        CMD_LWU   = 5'd5,
        CMD_LD    = 5'd6,
        CMD_LDC1  = 5'd7,
        CMD_SB    = 5'd8,
        CMD_SH    = 5'd9,
        CMD_SW    = 5'd10,
        CMD_SD    = 5'd11,
        CMD_SDC1  = 5'd12,
        CMD_LWL   = 5'd13,
        CMD_LWR   = 5'd14,
        CMD_LDL   = 5'd15,
        CMD_LDR   = 5'd16,
        CMD_SWL   = 5'd17,
        CMD_SWR   = 5'd18,
        CMD_SDL   = 5'd19,
        CMD_SDR   = 5'd20,
        CMD_LL    = 5'd21,
        CMD_SC    = 5'd22,
        CMD_CACHE = 5'd23
    } t_cmd;

    localparam logic [SIZE_W-1:0] SIZE_NONE  = 4'd0;
    localparam logic [SIZE_W-1:0] SIZE_BYTE  = 4'd1;
    localparam logic [SIZE_W-1:0] SIZE_HALF  = 4'd2;
    localparam logic [SIZE_W-1:0] SIZE_WORD  = 4'd4;
    localparam logic [SIZE_W-1:0] SIZE_DWORD = 4'd8;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr_low;
        logic [DATA_W-1:0] reg_value;
        logic [DATA_W-1:0] mem_value;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] reg_result;
        logic              reg_write;
        logic [DATA_W-1:0] store_data;
        logic [SIZE_W-1:0] store_size;
    } t_rsp;

endpackage

>>> design/mlsam_req_if.sv
// request channel: one memory instruction per transfer
// depends on mlsam_pkg
interface mlsam_req_if;
    import mlsam_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr_low;
    logic [DATA_W-1:0] reg_value;
    logic [DATA_W-1:0] mem_value;

    modport source (output valid, output cmd, output addr_low, output reg_value,
                    output mem_value, input ready);
    modport sink   (input valid, input cmd, input addr_low, input reg_value,
                    input mem_value, output ready);
endinterface

>>> design/mlsam_rsp_if.sv
// result channel: register write-back and store data per transfer
// depends on mlsam_pkg
interface mlsam_rsp_if;
    import mlsam_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] reg_result;
    logic              reg_write;
    logic [DATA_W-1:0] store_data;
    logic [SIZE_W-1:0] store_size;

    modport source (output valid, output reg_result, output reg_write,
                    output store_data, output store_size, input ready);
    modport sink   (input valid, input reg_result, input reg_write,
                    input store_data, input store_size, output ready);
endinterface

>>> design/mlsam_merge.sv
// combinational align, extend and byte-merge logic for one instruction
// depends on mlsam_pkg
module mlsam_merge (
    input  mlsam_pkg::t_req i_req,
    input  logic            i_link,
    output mlsam_pkg::t_rsp o_rsp,
    output logic            o_link_set
);
    import mlsam_pkg::*;

    localparam logic [DATA_W-1:0] ONES64 = '1;
    localparam logic [31:0]       ONES32 = '1;

    logic [DATA_W-1:0] w_reg;
    logic [DATA_W-1:0] w_mem;
    logic [31:0]       w_r32;
    logic [31:0]       w_m32;
    logic [1:0]        w_wa;
    logic [4:0]        w_wsh;   // (a mod 4) * 8
    logic [5:0]        w_wsh1;  // ((a mod 4) + 1) * 8
    logic [4:0]        w_wrsh;  // (3 - a mod 4) * 8
    logic [5:0]        w_dsh;   // a * 8
    logic [6:0]        w_dsh1;  // (a + 1) * 8
    logic [5:0]        w_drsh;  // (7 - a) * 8
    logic [31:0]       w_lwl32;

    assign w_reg  = i_req.reg_value;
    assign w_mem  = i_req.mem_value;
    assign w_r32  = w_reg[31:0];
    assign w_m32  = w_mem[31:0];
    assign w_wa   = i_req.addr_low[1:0];
    assign w_wsh  = {w_wa, 3'b000};
    assign w_wsh1 = {({1'b0, w_wa} + 3'd1), 3'b000};
    assign w_wrsh = {~w_wa, 3'b000};
    assign w_dsh  = {i_req.addr_low, 3'b000};
    assign w_dsh1 = {({1'b0, i_req.addr_low} + 4'd1), 3'b000};
    assign w_drsh = {~i_req.addr_low, 3'b000};

    assign w_lwl32 = (w_r32 & ~(ONES32 << w_wsh)) | (w_m32 << w_wsh);

    always_comb begin
        o_rsp      = '0;
        o_link_set = 1'b0;
        unique case (i_req.cmd) inside
            CMD_LB: begin
                o_rsp.reg_result = {{56{w_mem[7]}}, w_mem[7:0]};
                o_rsp.reg_write  = 1'b1;
            end
            CMD_LBU: begin
                o_rsp.reg_result = {56'd0, w_mem[7:0]};
                o_rsp.reg_write  = 1'b1;
            end
            CMD_LH: begin
                o_rsp.reg_result = {{48{w_mem[15]}}, w_mem[15:0]};
                o_rsp.reg_write  = 1'b1;
            end
            CMD_LHU: begin
                o_rsp.reg_result = {48'd0, w_mem[15:0]};
                o_rsp.reg_write  = 1'b1;
            end
            CMD_LW: begin
                o_rsp.reg_result = {{32{w_m32[31]}}, w_m32};
                o_rsp.reg_write  = 1'b1;
            end
            CMD_LWU: begin
                o_rsp.reg_result = {32'd0, w_m32};
                o_rsp.reg_write  = 1'b1;
            end
            CMD_LD, CMD_LDC1: begin
                o_rsp.reg_result = w_mem;
                o_rsp.reg_write  = 1'b1;
            end
            CMD_SB: begin
                o_rsp.store_data = {56'd0, w_reg[7:0]};
                o_rsp.store_size = SIZE_BYTE;
            end
            CMD_SH: begin
                o_rsp.store_data = {48'd0, w_reg[15:0]};
                o_rsp.store_size = SIZE_HALF;
            end
            CMD_SW: begin
                o_rsp.store_data = {32'd0, w_r32};
                o_rsp.store_size = SIZE_WORD;
            end
            CMD_SD, CMD_SDC1: begin
                o_rsp.store_data = w_reg;
                o_rsp.store_size = SIZE_DWORD;
            end
            CMD_LWL: begin
                o_rsp.reg_result = {{32{w_lwl32[31]}}, w_lwl32};
                o_rsp.reg_write  = 1'b1;
            end
            CMD_LWR: begin
                // whole word loaded: sign-extend, else upper register bits stay
                if (w_wa == 2'd3) begin
                    o_rsp.reg_result = {{32{w_m32[31]}}, w_m32};
                end else begin
                    o_rsp.reg_result = (w_reg & (ONES64 << w_wsh1))
                                     | {32'd0, (w_m32 >> w_wrsh)};
                end
                o_rsp.reg_write = 1'b1;
            end
            CMD_LDL: begin
                o_rsp.reg_result = (w_reg & ~(ONES64 << w_dsh)) | (w_mem << w_dsh);
                o_rsp.reg_write  = 1'b1;
            end
            CMD_LDR: begin
                // shift by 64 clears the kept part: full replacement
                o_rsp.reg_result = (w_reg & (ONES64 << w_dsh1)) | (w_mem >> w_drsh);
                o_rsp.reg_write  = 1'b1;
            end
            CMD_SWL: begin
                o_rsp.store_data = {32'd0, ((w_m32 & ~(ONES32 >> w_wsh)) | (w_r32 >> w_wsh))};
                o_rsp.store_size = SIZE_WORD;
            end
            CMD_SWR: begin
                o_rsp.store_data = {32'd0, ((w_m32 & (ONES32 >> w_wsh1)) | (w_r32 << w_wrsh))};
                o_rsp.store_size = SIZE_WORD;
            end
            CMD_SDL: begin
                o_rsp.store_data = (w_mem & ~(ONES64 >> w_dsh)) | (w_reg >> w_dsh);
                o_rsp.store_size = SIZE_DWORD;
            end
            CMD_SDR: begin
                o_rsp.store_data = (w_mem & (ONES64 >> w_dsh1)) | (w_reg << w_drsh);
                o_rsp.store_size = SIZE_DWORD;
            end
            CMD_LL: begin
                o_rsp.reg_result = {{32{w_m32[31]}}, w_m32};
                o_rsp.reg_write  = 1'b1;
                o_link_set       = 1'b1;
            end
            CMD_SC: begin
                if (i_link) begin
                    o_rsp.store_data = {32'd0, w_r32};
                    o_rsp.store_size = SIZE_WORD;
                end
                o_rsp.reg_result = {63'd0, i_link};
                o_rsp.reg_write  = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

>>> design/mips_load_store_align_merge_core.sv
// Load/store align and merge core for a 64-bit big-endian MIPS memory stage.
// Each request transfer carries one memory instruction (cmd), the low three
// address bits, the current target/source register and the aligned memory
// word already read; each result transfer gives the register write-back
// (reg_result, reg_write) and the store data and byte count (store_data,
// store_size, zero meaning no store). Loads sign- or zero-extend, the
// unaligned LWL/LWR/LDL/LDR/SWL/SWR/SDL/SDR forms merge bytes in big-endian
// order, and the offsets that cover the whole word or doubleword replace it
// completely. A load-linked bit is set by LL and never cleared except by
// reset; SC stores the low word only while it is set and returns the bit.
// Cache and unused command codes give an all-zero result. Timing: exactly
// one result per request, in order; one request per cycle sustained while
// the result sink is ready. A request sits in the input register, then one
// pass through the merge shifters loads the result register, which drives
// the result. The result register frees as soon as its transfer happens,
// so a stalled sink holds at most two requests before request ready drops.
// depends on mlsam_pkg, mlsam_req_if, mlsam_rsp_if, mlsam_merge and the
// assertion macro header
`include "mips_load_store_align_merge_core_defines.svh"

module mips_load_store_align_merge_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mlsam_req_if.sink   i_req,
    mlsam_rsp_if.source o_rsp
);
    import mlsam_pkg::*;

    // input stage
    logic r_in_valid;
    t_req r_in;
    // result stage
    logic r_out_valid;
    t_rsp r_out;
    // load-linked bit
    logic r_link;
    logic n_link;

    logic w_in_xfer;
    logic w_adv;        // input stage moves into the result stage
    t_rsp w_rsp;
    logic w_link_set;
    logic w_no_store;   // valid result without a store
    logic w_no_wb;      // valid result without a write-back

    // result register empties or drains this cycle
    assign w_adv       = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || !r_out_valid || o_rsp.ready;
    assign w_in_xfer   = i_req.valid && i_req.ready;

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in.cmd       <= i_req.cmd;
            r_in.addr_low  <= i_req.addr_low;
            r_in.reg_value <= i_req.reg_value;
            r_in.mem_value <= i_req.mem_value;
        end
    end

    // align, extend and merge
    mlsam_merge u_merge (
        .i_req      (r_in),
        .i_link     (r_link),
        .o_rsp      (w_rsp),
        .o_link_set (w_link_set)
    );

    // link bit follows instruction order since it updates as each item leaves
    always_comb begin
        n_link = r_link;
        if (w_adv && w_link_set) begin
            n_link = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_link <= n_link;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_rsp;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.reg_result = r_out.reg_result;
    assign o_rsp.reg_write  = r_out.reg_write;
    assign o_rsp.store_data = r_out.store_data;
    assign o_rsp.store_size = r_out.store_size;

    assign w_no_store = r_out_valid && (r_out.store_size == SIZE_NONE);
    assign w_no_wb    = r_out_valid && !r_out.reg_write;

    // no store means no store data; no write-back means zero result
    `MLSAM_ASSERT_NOW(a_store_zero, i_clk, i_rst_n, w_no_store, r_out.store_data == '0)
    `MLSAM_ASSERT_NOW(a_wb_zero, i_clk, i_rst_n, w_no_wb, r_out.reg_result == '0)
    // a completed LL leaves the link bit set
    `MLSAM_ASSERT_NEXT(a_ll_sets_link, i_clk, i_rst_n, w_adv && (r_in.cmd == CMD_LL), r_link)
    // an item that advances always shows up as a valid result
    `MLSAM_ASSERT_NEXT(a_adv_valid, i_clk, i_rst_n, w_adv, r_out_valid)

endmodule

>>> sim/testbench.sv
// self-checking bench for the load/store align and merge core: directed and random
// memory instructions under idle, stall and back-pressure, checked against a local predictor
// depends on mlsam_pkg, mlsam_req_if, mlsam_rsp_if and mips_load_store_align_merge_core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mlsam_pkg::*;

    localparam int unsigned HALF_PERIOD  = 6;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 6;

    localparam logic [DATA_W-1:0] LOW_WORD = 64'h0000_0000_FFFF_FFFF;
    localparam logic [DATA_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mlsam_req_if req_bus ();
    mlsam_rsp_if rsp_bus ();

    mips_load_store_align_merge_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // predictor state and scoreboard
    logic        link_bit = 1'b0;
    t_rsp        pending_results[$];
    int unsigned error_count = 0;
    int unsigned request_count = 0;
    int unsigned result_count = 0;
    int unsigned idle_cycles = 0;
    logic [31:0] cmds_seen = '0;
    logic [7:0]  offsets_seen = '0;

    // idling and hold-off controls
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned hold_cycles_left = 0;

    // expected result of one memory instruction; updates the load-linked bit
    function automatic t_rsp predict_access(input t_req acc);
        t_rsp        pred;
        logic [63:0] w32;
        logic [63:0] mem;
        logic [63:0] rv;
        logic [63:0] mask;
        logic [63:0] tmp;
        int unsigned sh;
        int unsigned a;
        pred = '0;
        mem  = acc.mem_value;
        rv   = acc.reg_value;
        w32  = mem & LOW_WORD;
        a    = int'(acc.addr_low);
        case (acc.cmd)
            CMD_LB: begin
                pred.reg_result = {{56{mem[7]}}, mem[7:0]};
                pred.reg_write  = 1'b1;
            end
            CMD_LBU: begin
                pred.reg_result = {56'd0, mem[7:0]};
                pred.reg_write  = 1'b1;
            end
            CMD_LH: begin
                pred.reg_result = {{48{mem[15]}}, mem[15:0]};
                pred.reg_write  = 1'b1;
            end
            CMD_LHU: begin
                pred.reg_result = {48'd0, mem[15:0]};
                pred.reg_write  = 1'b1;
            end
            CMD_LW, CMD_LL: begin
                pred.reg_result = {{32{mem[31]}}, mem[31:0]};
                pred.reg_write  = 1'b1;
                if (acc.cmd == CMD_LL) begin
                    link_bit = 1'b1;
                end
            end
            CMD_LWU: begin
                pred.reg_result = w32;
                pred.reg_write  = 1'b1;
            end
            CMD_LD, CMD_LDC1: begin
                pred.reg_result = mem;
                pred.reg_write  = 1'b1;
            end
            CMD_SB: begin
                pred.store_data = {56'd0, rv[7:0]};
                pred.store_size = SIZE_BYTE;
            end
            CMD_SH: begin
                pred.store_data = {48'd0, rv[15:0]};
                pred.store_size = SIZE_HALF;
            end
            CMD_SW: begin
                pred.store_data = rv & LOW_WORD;
                pred.store_size = SIZE_WORD;
            end
            CMD_SD, CMD_SDC1: begin
                pred.store_data = rv;
                pred.store_size = SIZE_DWORD;
            end
            CMD_LWL: begin
                sh   = 8 * (a % 4);
                mask = (64'd1 << sh) - 64'd1;
                tmp  = (rv & mask) | (w32 << sh);
                pred.reg_result = {{32{tmp[31]}}, tmp[31:0]};
                pred.reg_write  = 1'b1;
            end
            CMD_LWR: begin
                sh = 8 * (a % 4 + 1);
                // whole word loaded: sign extension replaces the upper half
                if (sh == 32) begin
                    pred.reg_result = {{32{w32[31]}}, w32[31:0]};
                end else begin
                    mask = (64'd1 << sh) - 64'd1;
                    pred.reg_result = (rv & ~mask) | (w32 >> (32 - sh));
                end
                pred.reg_write = 1'b1;
            end
            CMD_LDL: begin
                sh   = 8 * a;
                mask = (64'd1 << sh) - 64'd1;
                pred.reg_result = (rv & mask) | (mem << sh);
                pred.reg_write  = 1'b1;
            end
            CMD_LDR: begin
                sh = 8 * (a + 1);
                if (sh == 64) begin
                    pred.reg_result = mem;
                end else begin
                    mask = (64'd1 << sh) - 64'd1;
                    pred.reg_result = (rv & ~mask) | (mem >> (64 - sh));
                end
                pred.reg_write = 1'b1;
            end
            CMD_SWL: begin
                sh   = 8 * (a % 4);
                mask = LOW_WORD >> sh;
                pred.store_data = ((w32 & ~mask) | ((rv & LOW_WORD) >> sh)) & LOW_WORD;
                pred.store_size = SIZE_WORD;
            end
            CMD_SWR: begin
                sh   = 8 * (a % 4 + 1);
                mask = (sh == 32) ? 64'd0 : (LOW_WORD >> sh);
                pred.store_data = ((w32 & mask) | ((rv << (32 - sh)) & LOW_WORD)) & LOW_WORD;
                pred.store_size = SIZE_WORD;
            end
            CMD_SDL: begin
                sh   = 8 * a;
                mask = ALL_ONES >> sh;
                pred.store_data = (mem & ~mask) | (rv >> sh);
                pred.store_size = SIZE_DWORD;
            end
            CMD_SDR: begin
                sh   = 8 * (a + 1);
                mask = (sh == 64) ? 64'd0 : (ALL_ONES >> sh);
                pred.store_data = (mem & mask) | (rv << (64 - sh));
                pred.store_size = SIZE_DWORD;
            end
            CMD_SC: begin
                // conditional store of the low word; the link bit is returned, not cleared
                if (link_bit) begin
                    pred.store_data = rv & LOW_WORD;
                    pred.store_size = SIZE_WORD;
                end
                pred.reg_result = {63'd0, link_bit};
                pred.reg_write  = 1'b1;
            end
            default: begin
                // cache op and unused codes: all-zero result
            end
        endcase
        return pred;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            error_count++;
        end
    endtask

    // request and result monitor with the no-progress watchdog
    always @(posedge clk) begin : monitor
        t_req acc;
        t_rsp want;
        logic req_fire;
        logic rsp_fire;
        if (rst_n) begin
            req_fire = req_bus.valid && req_bus.ready;
            rsp_fire = rsp_bus.valid && rsp_bus.ready;
            if (req_fire) begin
                acc.cmd       = req_bus.cmd;
                acc.addr_low  = req_bus.addr_low;
                acc.reg_value = req_bus.reg_value;
                acc.mem_value = req_bus.mem_value;
                pending_results.push_back(predict_access(acc));
                cmds_seen[acc.cmd]         = 1'b1;
                offsets_seen[acc.addr_low] = 1'b1;
                request_count++;
            end
            if (rsp_fire) begin
                result_count++;
                if (pending_results.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("reg_result", want.reg_result, rsp_bus.reg_result);
                    compare_field("reg_write", 64'(want.reg_write), 64'(rsp_bus.reg_write));
                    compare_field("store_data", want.store_data, rsp_bus.store_data);
                    compare_field("store_size", 64'(want.store_size), 64'(rsp_bus.store_size));
                end
            end
            if (req_fire || rsp_fire) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("no transfer for %0d cycles", STALL_LIMIT);
                    $display("FAIL mips_load_store_align_merge_core");
                    $finish;
                end
            end
        end
    end

    // result side: random stalls, or a long hold-off while one is pending
    always @(negedge clk) begin
        if (hold_cycles_left != 0) begin
            rsp_bus.ready    <= 1'b0;
            hold_cycles_left <= hold_cycles_left - 1;
        end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
        @(posedge clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // one request transfer, with random idle cycles in front of it
    task automatic send_access(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] reg_value,
                               input logic [DATA_W-1:0] mem_value);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.cmd       <= cmd;
        req_bus.addr_low  <= addr;
        req_bus.reg_value <= reg_value;
        req_bus.mem_value <= mem_value;
        do begin
            @(posedge clk);
        end while (!req_bus.ready);
    endtask

    function automatic logic [DATA_W-1:0] rand_data();
        case ($urandom_range(9))
            0: return '0;
            1: return ALL_ONES;
            2: return {$urandom, $urandom} | 64'h8080_8080_8080_8080;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] rand_cmd();
        // a few unused codes mixed in with the defined operations
        if ($urandom_range(99) < 4) begin
            return CMD_W'($urandom_range(31, 24));
        end
        return CMD_W'($urandom_range(CMD_CACHE, CMD_LB));
    endfunction

    // sc before any ll: nothing stored, zero returned
    task automatic test_link_clear();
        send_access(CMD_SC, 3'd0, 64'hDEAD_BEEF_0123_4567, ALL_ONES);
    endtask

    // sign and zero extension at the extremes, upper memory bits as junk
    task automatic test_plain_loads();
        send_access(CMD_LB,   3'd0, ALL_ONES, 64'h1234_5678_9ABC_DE80);
        send_access(CMD_LBU,  3'd1, '0,       ALL_ONES);
        send_access(CMD_LH,   3'd2, ALL_ONES, 64'h5555_5555_5555_8000);
        send_access(CMD_LHU,  3'd6, '0,       ALL_ONES);
        send_access(CMD_LW,   3'd4, '0,       64'h7FFF_FFFF_8000_0000);
        send_access(CMD_LWU,  3'd0, '0,       ALL_ONES);
        send_access(CMD_LD,   3'd0, '0,       ALL_ONES);
        send_access(CMD_LDC1, 3'd0, ALL_ONES, 64'h0123_4567_89AB_CDEF);
    endtask

    task automatic test_plain_stores();
        send_access(CMD_SB,   3'd3, ALL_ONES,               ALL_ONES);
        send_access(CMD_SH,   3'd2, 64'hFEDC_BA98_7654_8001, ALL_ONES);
        send_access(CMD_SW,   3'd4, 64'h8000_0001_FFFF_FFFE, '0);
        send_access(CMD_SD,   3'd0, ALL_ONES,               '0);
        send_access(CMD_SDC1, 3'd0, '0,                     ALL_ONES);
    endtask

    // partial merges and the offsets that cover the whole word or doubleword
    task automatic test_merge_edges();
        send_access(CMD_LWL, 3'd7, 64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_0000_0080);
        send_access(CMD_LWR, 3'd3, 64'h0123_4567_89AB_CDEF, 64'h0000_0000_8765_4321);
        send_access(CMD_LWR, 3'd4, ALL_ONES,               64'h0000_0000_8000_0000);
        send_access(CMD_LDL, 3'd7, ALL_ONES,               64'h0102_0304_0506_0708);
        send_access(CMD_LDR, 3'd7, ALL_ONES,               64'h8877_6655_4433_2211);
        send_access(CMD_SWL, 3'd0, 64'hAAAA_AAAA_1234_5678, ALL_ONES);
        send_access(CMD_SWR, 3'd3, 64'h5555_5555_CAFE_F00D, ALL_ONES);
        send_access(CMD_SDL, 3'd0, 64'h0F0E_0D0C_0B0A_0908, ALL_ONES);
        send_access(CMD_SDR, 3'd7, 64'h0F0E_0D0C_0B0A_0908, ALL_ONES);
    endtask

    // ll sets the link bit for good, so sc stores from here on
    task automatic test_link_set();
        send_access(CMD_LL,    3'd4, '0,                     64'h0000_0000_8000_0000);
        send_access(CMD_SC,    3'd0, 64'hFFFF_FFFF_1357_9BDF, '0);
        send_access(CMD_CACHE, 3'd7, ALL_ONES,               ALL_ONES);
    endtask

    task automatic test_random_mix(input int unsigned n_items);
        for (int unsigned i = 0; i < n_items; i++) begin
            send_access(rand_cmd(), ADDR_W'($urandom_range(7)), rand_data(), rand_data());
        end
    endtask

    // result side held off while requests keep coming, so the core backs up
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_cycles_left = HOLD_CYCLES;
        test_random_mix(40);
    endtask

    task automatic finish_run();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end
        $display("checked %0d results for %0d requests, %0d command codes, %0d address offsets",
                 result_count, request_count, $countones(cmds_seen), $countones(offsets_seen));
        $display("covered sc with link clear and set, full-width merges, stalls and back-pressure");
        if (error_count == 0) begin
            $display("PASS mips_load_store_align_merge_core");
        end else begin
            $display("FAIL mips_load_store_align_merge_core");
        end
        $finish;
    endtask

    initial begin
        req_bus.valid     = 1'b0;
        req_bus.cmd       = '0;
        req_bus.addr_low  = '0;
        req_bus.reg_value = '0;
        req_bus.mem_value = '0;
        rsp_bus.ready     = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_idling(32, 69);
        test_link_clear();
        test_plain_loads();
        test_plain_stores();
        test_merge_edges();
        test_link_set();
        test_random_mix(440);
        set_idling(69, 32);
        test_random_mix(440);
        test_backpressure();
        set_idling(0, 0);
        test_random_mix(420);
        finish_run();
    end

endmodule
